[hdl/qwf_pkg.sv]
// Shared constants, types and helpers of the 4-mer window filter.
package qwf_pkg;

    localparam int MAX_QUERY_DEF = 1024;
    localparam int POS_WIDTH_DEF = 32;

    localparam int HIST_BINS = 256;
    localparam int BIN_W     = 8;
    localparam int CNT_W     = 10;
    localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

    localparam int SCORE_W = 11;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 11'd2047;
    localparam int SCORE_BIAS = 3;
    localparam int MIN_QUERY  = 5;

    localparam int CFG_W = 11;
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_QUERY_LEN = 1'b1;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 11'd1;
    localparam logic [CFG_W-1:0] QUERY_LEN_RST = 11'd64;

    localparam logic [1:0] REQ_QUERY = 2'd0;
    localparam logic [1:0] REQ_DB    = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    localparam int RES_W     = 32;
    localparam int OUT_W     = 2 * RES_W;
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic             en;
        logic [BIN_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } t_hist_wr;

    function automatic logic [1:0] code_of(input logic [7:0] c);
        logic [1:0] r;
        unique case (c)
            CHAR_A:  r = 2'd0;
            CHAR_C:  r = 2'd1;
            CHAR_G:  r = 2'd2;
            CHAR_T:  r = 2'd3;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/qwf_hist_mem.sv]
// 256-bin count memory: two registered reads, one write, per-bin valid bits.
module qwf_hist_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clr,
    input  qwf_pkg::t_hist_wr          i_wr,
    input  logic [qwf_pkg::BIN_W-1:0]  i_rd_addr_a,
    input  logic [qwf_pkg::BIN_W-1:0]  i_rd_addr_b,
    output logic [qwf_pkg::CNT_W-1:0]  o_rd_data_a,
    output logic [qwf_pkg::CNT_W-1:0]  o_rd_data_b
);

    logic [qwf_pkg::CNT_W-1:0]     mem [qwf_pkg::HIST_BINS];
    logic [qwf_pkg::HIST_BINS-1:0] r_valid;
    logic [qwf_pkg::CNT_W-1:0]     r_rd_a;
    logic [qwf_pkg::CNT_W-1:0]     r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_a <= r_valid[i_rd_addr_a] ? mem[i_rd_addr_a] : '0;
        r_rd_b <= r_valid[i_rd_addr_b] ? mem[i_rd_addr_b] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_clr) begin
                r_valid <= '0;
            end
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

[hdl/qwf_ring.sv]
// Ring of recent database 4-mers with a registered read port.
module qwf_ring #(
    parameter int DEPTH = qwf_pkg::MAX_QUERY_DEF + 1
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [qwf_pkg::BIN_W-1:0]  i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [qwf_pkg::BIN_W-1:0]  o_rd_data
);

    logic [qwf_pkg::BIN_W-1:0] mem [DEPTH];
    logic [qwf_pkg::BIN_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

[hdl/qwf_out_fifo.sv]
// Small result queue between the scoring pipeline and the output stream.
module qwf_out_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [qwf_pkg::OUT_W-1:0]   i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [qwf_pkg::OUT_W-1:0]   o_data,
    output logic [$clog2(qwf_pkg::OUT_DEPTH):0] o_count
);

    localparam int PW = $clog2(qwf_pkg::OUT_DEPTH);

    logic [qwf_pkg::OUT_W-1:0] mem [qwf_pkg::OUT_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          w_pop;

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hdl/qgram_window_filter.sv]
// 4-mer q-gram window filter, top level.
// A new request is not taken while the previous one sits in the first stage register;
// the histogram read-modify-write path sets this. A range result passes r_s1 and r_s2
// before it enters the output queue, and is shown on the output stream in queue order.
// Reset: synchronous, active low; histograms read as zero at once, no clearing pass.
// The request input stalls while the 4-entry result queue may overflow.
module qgram_window_filter #(
    parameter int MAX_QUERY = qwf_pkg::MAX_QUERY_DEF,
    parameter int POS_WIDTH = qwf_pkg::POS_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] base_char
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] range_start, [63:32] range_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int RING_LEN = MAX_QUERY + 1;
    localparam int RA_W     = $clog2(RING_LEN);
    localparam int LEN_W    = $clog2(MAX_QUERY + 1);
    localparam int FILL_W   = $clog2(RING_LEN + 1);
    localparam int CMP_W    = (POS_WIDTH > LEN_W) ? POS_WIDTH : LEN_W;
    localparam int BW       = qwf_pkg::BIN_W;
    localparam int CW       = qwf_pkg::CNT_W;
    localparam int SW       = qwf_pkg::SCORE_W;

    typedef struct packed {
        logic                 vld;
        logic                 q_upd;
        logic                 q_inc;
        logic [BW-1:0]        k_q;
        logic                 base;
        logic                 chk;
        logic                 rem;
        logic                 add;
        logic [BW-1:0]        k_a;
        logic [BW-1:0]        k_r;
        logic [POS_WIDTH-1:0] win_pos;
        logic [LEN_W-1:0]     len;
        logic                 emit_end;
        logic                 restart;
        logic                 clr_q;
    } t_stage;

    logic [qwf_pkg::CFG_W-1:0] r_thr;
    logic [qwf_pkg::CFG_W-1:0] r_qlen;

    logic [5:0]           r_qsh;
    logic [LEN_W-1:0]     r_qcnt;
    logic [5:0]           r_dbsh;
    logic [FILL_W-1:0]    r_fill;
    logic [RA_W-1:0]      r_wp;
    logic [POS_WIDTH-1:0] r_pos;
    logic [LEN_W-1:0]     r_win_len;

    logic [SW-1:0]        r_score;
    logic                 r_open;
    logic [POS_WIDTH-1:0] r_open_start;
    logic [POS_WIDTH-1:0] r_open_end;

    logic                 r_fw_vld;
    logic [BW-1:0]        r_fw_addr;
    logic [CW-1:0]        r_fw_val;
    logic                 r_pend_en;

    t_stage r_s1;
    t_stage r_s2;
    t_stage n_s1;
    t_stage n_s2;

    logic                 w_acc;
    logic [1:0]           w_b;
    logic [31:0]          w_ql;
    logic [LEN_W-1:0]     w_eff;
    logic [LEN_W-1:0]     w_len;
    logic [RA_W:0]        w_rsum;
    logic [RA_W-1:0]      w_raddr;
    logic [BW-1:0]        w_ring_q;

    logic [CW-1:0] w_win_a;
    logic [CW-1:0] w_win_b;
    logic [CW-1:0] w_qry_a;
    logic [CW-1:0] w_qry_b;
    logic [BW-1:0] w_qry_addr_a;

    qwf_pkg::t_hist_wr w_win_wr;
    qwf_pkg::t_hist_wr w_qry_wr;

    logic [CW-1:0]  w_wr_raw;
    logic [CW-1:0]  w_wr_new;
    logic [CW-1:0]  w_wa_raw;
    logic [CW-1:0]  w_wa_cur;
    logic [CW-1:0]  w_wa_new;
    logic [SW-1:0]  w_sc_mid;
    logic [SW-1:0]  w_sc_fin;
    logic           w_cand;
    logic           w_gap;
    logic           w_push;
    logic [$clog2(qwf_pkg::OUT_DEPTH):0] w_cnt;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= qwf_pkg::THRESHOLD_RST;
            r_qlen <= qwf_pkg::QUERY_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qwf_pkg::CFG_THRESHOLD: r_thr  <= i_cfg_data;
                qwf_pkg::CFG_QUERY_LEN: r_qlen <= i_cfg_data;
                default:                r_thr  <= r_thr;
            endcase
        end
    end

    // request intake
    assign o_s_axis_tready = !r_s1.vld &&
        ((4'(w_cnt) + 4'(r_s2.vld)) < 4'(qwf_pkg::OUT_DEPTH));
    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_b   = qwf_pkg::code_of(i_s_axis_tdata);
    assign w_ql  = 32'(r_qlen);

    always_comb begin
        if (w_ql < 32'(qwf_pkg::MIN_QUERY)) begin
            w_eff = LEN_W'(qwf_pkg::MIN_QUERY);
        end else if (w_ql > 32'(MAX_QUERY)) begin
            w_eff = LEN_W'(MAX_QUERY);
        end else begin
            w_eff = LEN_W'(w_ql);
        end
    end

    assign w_len  = (r_fill == '0) ? w_eff : r_win_len;
    assign w_rsum = (RA_W+1)'(r_wp) + (RA_W+1)'(RING_LEN) - (RA_W+1)'(w_len) + (RA_W+1)'(3);
    assign w_raddr = (w_rsum >= (RA_W+1)'(RING_LEN)) ?
                     RA_W'(w_rsum - (RA_W+1)'(RING_LEN)) : RA_W'(w_rsum);

    always_comb begin
        n_s1          = '0;
        n_s1.vld      = w_acc;
        n_s1.k_q      = {r_qsh, w_b};
        n_s1.k_a      = {r_dbsh, w_b};
        n_s1.q_inc    = (r_qcnt >= LEN_W'(3));
        n_s1.win_pos  = r_pos - POS_WIDTH'(w_len);
        n_s1.len      = w_len;
        unique case (i_s_axis_tuser)
            qwf_pkg::REQ_QUERY: begin
                n_s1.q_upd = (r_fill == '0) && (r_qcnt < w_eff);
            end
            qwf_pkg::REQ_DB: begin
                n_s1.base = 1'b1;
                n_s1.chk  = (r_fill >= FILL_W'(w_len));
                n_s1.rem  = n_s1.chk;
                n_s1.add  = (r_fill >= FILL_W'(3));
            end
            qwf_pkg::REQ_END: begin
                n_s1.emit_end = 1'b1;
                n_s1.restart  = 1'b1;
            end
            default: begin
                n_s1.restart = 1'b1;
                n_s1.clr_q   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qsh     <= '0;
            r_qcnt    <= '0;
            r_dbsh    <= '0;
            r_fill    <= '0;
            r_wp      <= '0;
            r_pos     <= '0;
            r_win_len <= '0;
        end else if (w_acc) begin
            if (n_s1.q_upd) begin
                r_qsh  <= {r_qsh[3:0], w_b};
                r_qcnt <= r_qcnt + 1'b1;
            end
            if (n_s1.base) begin
                if (r_fill == '0) begin
                    r_win_len <= w_eff;
                end
                r_dbsh <= {r_dbsh[3:0], w_b};
                if (r_fill < FILL_W'(RING_LEN)) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_wp  <= (r_wp == RA_W'(RING_LEN - 1)) ? '0 : r_wp + 1'b1;
                r_pos <= r_pos + 1'b1;
            end
            if (n_s1.restart) begin
                r_fill <= '0;
                r_wp   <= '0;
                r_pos  <= '0;
            end
            if (n_s1.clr_q) begin
                r_qsh  <= '0;
                r_qcnt <= '0;
            end
        end
    end

    qwf_ring #(
        .DEPTH (RING_LEN)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_acc && n_s1.base),
        .i_wr_addr (r_wp),
        .i_wr_data (n_s1.k_a),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_raddr),
        .o_rd_data (w_ring_q)
    );

    // pipeline stages
    always_comb begin
        n_s2     = r_s1;
        n_s2.k_r = w_ring_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign w_qry_addr_a = r_s1.q_upd ? r_s1.k_q : w_ring_q;

    qwf_hist_mem u_win_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (r_s2.vld && r_s2.restart),
        .i_wr        (w_win_wr),
        .i_rd_addr_a (w_ring_q),
        .i_rd_addr_b (r_s1.k_a),
        .o_rd_data_a (w_win_a),
        .o_rd_data_b (w_win_b)
    );

    qwf_hist_mem u_qry_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (r_s2.vld && r_s2.clr_q),
        .i_wr        (w_qry_wr),
        .i_rd_addr_a (w_qry_addr_a),
        .i_rd_addr_b (r_s1.k_a),
        .o_rd_data_a (w_qry_a),
        .o_rd_data_b (w_qry_b)
    );

    // score update: remove the oldest 4-mer, then add the newest
    assign w_wr_raw = (r_fw_vld && r_fw_addr == r_s2.k_r) ? r_fw_val : w_win_a;
    assign w_wa_raw = (r_fw_vld && r_fw_addr == r_s2.k_a) ? r_fw_val : w_win_b;

    always_comb begin
        w_sc_mid = r_score;
        w_wr_new = w_wr_raw;
        if (r_s2.rem && w_wr_raw != '0) begin
            if (w_wr_raw <= w_qry_a && r_score != '0) begin
                w_sc_mid = r_score - 1'b1;
            end
            w_wr_new = w_wr_raw - 1'b1;
        end
        w_wa_cur = (r_s2.rem && r_s2.k_a == r_s2.k_r) ? w_wr_new : w_wa_raw;
        w_sc_fin = w_sc_mid;
        w_wa_new = w_wa_cur;
        if (r_s2.add) begin
            if (w_wa_cur < w_qry_b && w_sc_mid != qwf_pkg::SCORE_MAX) begin
                w_sc_fin = w_sc_mid + 1'b1;
            end
            if (w_wa_cur != qwf_pkg::CNT_MAX) begin
                w_wa_new = w_wa_cur + 1'b1;
            end
        end
    end

    assign w_cand = ((SW+1)'(r_score) + (SW+1)'(qwf_pkg::SCORE_BIAS)) >= (SW+1)'(r_thr);
    assign w_gap  = CMP_W'(r_s2.win_pos - r_open_end) > CMP_W'(r_s2.len);
    assign w_push = r_s2.vld && r_open &&
                    ((r_s2.chk && !w_cand && w_gap) || r_s2.emit_end);

    always_comb begin
        if (r_s2.vld && r_s2.rem) begin
            w_win_wr.en   = 1'b1;
            w_win_wr.addr = r_s2.k_r;
            w_win_wr.data = w_wr_new;
        end else begin
            w_win_wr.en   = r_pend_en;
            w_win_wr.addr = r_fw_addr;
            w_win_wr.data = r_fw_val;
        end
        w_qry_wr.en   = r_s2.vld && r_s2.q_upd && r_s2.q_inc;
        w_qry_wr.addr = r_s2.k_q;
        w_qry_wr.data = (w_qry_a == qwf_pkg::CNT_MAX) ? w_qry_a : w_qry_a + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score      <= '0;
            r_open       <= 1'b0;
            r_open_start <= '0;
            r_open_end   <= '0;
            r_fw_vld     <= 1'b0;
            r_fw_addr    <= '0;
            r_fw_val     <= '0;
            r_pend_en    <= 1'b0;
        end else begin
            r_pend_en <= r_s2.vld && r_s2.add;
            if (r_s2.vld) begin
                if (r_s2.base) begin
                    r_score <= w_sc_fin;
                end
                if (r_s2.add) begin
                    r_fw_vld  <= 1'b1;
                    r_fw_addr <= r_s2.k_a;
                    r_fw_val  <= w_wa_new;
                end
                if (r_s2.chk) begin
                    if (w_cand) begin
                        if (!r_open) begin
                            r_open       <= 1'b1;
                            r_open_start <= r_s2.win_pos;
                            r_open_end   <= r_s2.win_pos + 1'b1;
                        end else begin
                            r_open_end <= r_s2.win_pos;
                        end
                    end else if (w_push) begin
                        r_open <= 1'b0;
                    end
                end
                if (r_s2.restart) begin
                    r_score      <= '0;
                    r_open       <= 1'b0;
                    r_open_start <= '0;
                    r_open_end   <= '0;
                    r_fw_vld     <= 1'b0;
                end
            end
        end
    end

    qwf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({qwf_pkg::RES_W'(r_open_end), qwf_pkg::RES_W'(r_open_start)}),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_count (w_cnt)
    );

endmodule
